// ===== src/kdst_pkg.sv =====
// Shared types and constants of the keyed device slot table.
`default_nettype none

package kdst_pkg;

    // Request codes on the input tuser
    localparam logic [1:0] REQ_ADV   = 2'd0;
    localparam logic [1:0] REQ_SWEEP = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_OFFLINE = 2'd0;
    localparam logic [1:0] CFG_REMOVE  = 2'd1;
    localparam logic [1:0] CFG_AGE_CAP = 2'd2;

    localparam logic [7:0] MIN_PAYLOAD  = 8'd6;
    localparam logic [7:0] BATT_PAYLOAD = 8'd7;
    localparam logic [7:0] OCC_PAYLOAD  = 8'd8;
    localparam logic [8:0] BATT_NONE    = 9'h1FF;

    // floor(x / 1000) = (x * AGE_RECIP) >> AGE_SHIFT for any 32-bit x
    localparam logic [28:0] AGE_RECIP = 29'd274877907;
    localparam int          AGE_SHIFT = 38;

    typedef enum logic [1:0] {
        K_NOP,
        K_ADV,
        K_SWEEP,
        K_QUERY
    } kdst_kind_t;

    typedef enum logic [1:0] {
        ST_EMPTY,
        ST_ACTIVE,
        ST_OFFLINE
    } kdst_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ADV_SCAN,
        B_ADV_WRITE,
        B_SWEEP,
        B_QUERY,
        B_AGE_MUL,
        B_AGE_CAP,
        B_DONE
    } kdst_state_t;

    typedef struct packed {
        kdst_kind_t  kind;
        logic [31:0] now_ms;
        logic [47:0] device_addr;
        logic [31:0] motion_count;
        logic [8:0]  battery;
        logic [7:0]  occupied;
        logic [3:0]  query_slot;
    } kdst_item_t;

    typedef struct packed {
        logic [31:0] offline_after_ms;
        logic [31:0] remove_after_ms;
        logic [15:0] age_cap_seconds;
    } kdst_cfg_t;

    typedef struct packed {
        logic        slot_valid;
        logic        publish;
        logic        table_full;
        logic [2:0]  slot_index;
        logic [31:0] count_out;
        logic [8:0]  battery_out;
        logic [7:0]  occupied_out;
        logic [15:0] age_seconds;
        logic [3:0]  visible_count;
    } kdst_res_t;

endpackage

`default_nettype wire

// ===== src/kdst_front.sv =====
// Front end: unpacks an input transfer and classifies it for the back end.
`default_nettype none

module kdst_front
    import kdst_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic [143:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    output kdst_item_t        item
);

    logic [7:0] payload_len;
    logic [7:0] battery_raw;
    logic [7:0] occupied_raw;
    logic [3:0] query_slot;

    assign payload_len  = s_tdata[87:80];
    assign battery_raw  = s_tdata[127:120];
    assign occupied_raw = s_tdata[135:128];
    assign query_slot   = s_tdata[139:136];

    always_comb
    begin
        item.now_ms       = s_tdata[31:0];
        item.device_addr  = s_tdata[79:32];
        item.motion_count = s_tdata[119:88];
        item.battery      = (payload_len >= BATT_PAYLOAD) ? {1'b0, battery_raw} : BATT_NONE;
        item.occupied     = (payload_len >= OCC_PAYLOAD) ? occupied_raw : 8'd0;
        item.query_slot   = query_slot;
        // Short payloads, out-of-range queries and unknown codes only report the visible count
        unique case (s_tuser)
            REQ_ADV:   item.kind = (payload_len >= MIN_PAYLOAD) ? K_ADV : K_NOP;
            REQ_SWEEP: item.kind = K_SWEEP;
            REQ_QUERY: item.kind = (32'(query_slot) < SLOTS) ? K_QUERY : K_NOP;
            default:   item.kind = K_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/kdst_fifo.sv =====
// Two-entry queue between the front and back ends.
`default_nettype none

module kdst_fifo
    import kdst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire kdst_item_t in_item,
    output logic      out_valid,
    input  wire logic out_pop,
    output kdst_item_t out_item
);

    kdst_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

// ===== src/kdst_back.sv =====
// Back end: slot table, per-slot scan sequencer, age divider and result register.
`default_nettype none

module kdst_back
    import kdst_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire kdst_item_t  q_item,
    input  wire kdst_cfg_t   cfg,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    output logic [2:0]       m_tuser
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int VW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    kdst_state_t  state_reg;
    kdst_state_t  state_next;

    kdst_status_t status_reg [SLOTS];
    logic [47:0]  addr_mem   [SLOTS];
    logic [31:0]  motion_mem [SLOTS];
    logic [8:0]   batt_mem   [SLOTS];
    logic [31:0]  seen_mem   [SLOTS];

    kdst_item_t   item_reg;
    logic [SW-1:0] idx_reg;
    logic         hit_found_reg;
    logic [SW-1:0] hit_idx_reg;
    logic         free_found_reg;
    logic [SW-1:0] free_idx_reg;
    logic [VW-1:0] vis_reg;
    logic [VW-1:0] sweep_vis_reg;
    kdst_res_t    res_reg;
    logic [31:0]  diff_reg;
    logic [60:0]  prod_reg;
    logic         out_valid_reg;
    kdst_res_t    out_res_reg;

    logic          scan_last;
    logic          out_load;
    logic [SW-1:0] rd_idx;
    kdst_status_t  rd_status;
    logic [47:0]   rd_addr;
    logic [31:0]   rd_motion;
    logic [8:0]    rd_batt;
    logic [31:0]   rd_seen;
    logic [31:0]   age_ms;
    logic          slot_used;
    logic          hit;
    kdst_status_t  sweep_status;
    logic [VW-1:0] sweep_vis;
    logic [SW-1:0] wr_idx;
    logic          adv_ok;
    logic          pub;
    logic [VW-1:0] wr_plus;
    logic [22:0]   secs;
    kdst_res_t     res_out;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.kind)
                        K_ADV:   state_next = B_ADV_SCAN;
                        K_SWEEP: state_next = B_SWEEP;
                        K_QUERY: state_next = B_QUERY;
                        K_NOP:   state_next = B_DONE;
                        default: state_next = B_DONE;
                    endcase
                end
            end
            B_ADV_SCAN:  if (scan_last) state_next = B_ADV_WRITE;
            B_ADV_WRITE: state_next = B_DONE;
            B_SWEEP:     if (scan_last) state_next = B_DONE;
            B_QUERY:     state_next = B_AGE_MUL;
            B_AGE_MUL:   state_next = B_AGE_CAP;
            B_AGE_CAP:   state_next = B_DONE;
            B_DONE:      if (out_load) state_next = B_IDLE;
            default:     state_next = B_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        q_pop     = (state_reg == B_IDLE) && q_valid;
        scan_last = (idx_reg == LAST_IDX);
        out_load  = (state_reg == B_DONE) && (!out_valid_reg || m_tready);
        unique case (state_reg)
            B_ADV_WRITE: rd_idx = hit_idx_reg;
            B_QUERY:     rd_idx = SW'(item_reg.query_slot);
            default:     rd_idx = idx_reg;
        endcase
    end

    // Slot read and per-slot decisions
    always_comb
    begin
        rd_status = status_reg[rd_idx];
        rd_addr   = addr_mem[rd_idx];
        rd_motion = motion_mem[rd_idx];
        rd_batt   = batt_mem[rd_idx];
        rd_seen   = seen_mem[rd_idx];
        age_ms    = item_reg.now_ms - rd_seen;
        slot_used = (rd_status != ST_EMPTY);
        hit       = slot_used && (rd_addr == item_reg.device_addr);

        priority if (!slot_used || (age_ms > cfg.remove_after_ms))
            sweep_status = ST_EMPTY;
        else if ((age_ms > cfg.offline_after_ms) && (rd_status == ST_ACTIVE))
            sweep_status = ST_OFFLINE;
        else
            sweep_status = rd_status;
        sweep_vis = (sweep_status != ST_EMPTY) ? (VW'(idx_reg) + VW'(1)) : sweep_vis_reg;

        wr_idx  = hit_found_reg ? hit_idx_reg : free_idx_reg;
        adv_ok  = hit_found_reg || free_found_reg;
        pub     = !hit_found_reg || (rd_motion != item_reg.motion_count)
                  || (rd_batt != item_reg.battery);
        wr_plus = VW'(wr_idx) + VW'(1);
        secs    = prod_reg[60:AGE_SHIFT];

        // merge the visible count into the finished result
        res_out               = res_reg;
        res_out.visible_count = 4'(vis_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vis_reg        <= '0;
            sweep_vis_reg  <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
                status_reg[i] <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                B_IDLE:
                begin
                    idx_reg        <= '0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    sweep_vis_reg  <= '0;
                end
                B_ADV_SCAN:
                begin
                    if (hit)
                        hit_found_reg <= 1'b1;
                    if (!slot_used)
                        free_found_reg <= 1'b1;
                    idx_reg <= idx_reg + SW'(1);
                end
                B_ADV_WRITE:
                begin
                    if (adv_ok)
                    begin
                        status_reg[wr_idx] <= ST_ACTIVE;
                        if (wr_plus > vis_reg)
                            vis_reg <= wr_plus;
                    end
                end
                B_SWEEP:
                begin
                    status_reg[idx_reg] <= sweep_status;
                    sweep_vis_reg       <= sweep_vis;
                    idx_reg             <= idx_reg + SW'(1);
                    if (scan_last)
                        vis_reg <= sweep_vis;
                end
                default:
                begin
                end
            endcase
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Slot data and result payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    item_reg <= q_item;
                    res_reg  <= '0;
                end
            end
            B_ADV_SCAN:
            begin
                // keep the first match and the first empty slot
                if (hit && !hit_found_reg)
                    hit_idx_reg <= idx_reg;
                if (!slot_used && !free_found_reg)
                    free_idx_reg <= idx_reg;
            end
            B_ADV_WRITE:
            begin
                if (adv_ok)
                begin
                    addr_mem[wr_idx]     <= item_reg.device_addr;
                    motion_mem[wr_idx]   <= item_reg.motion_count;
                    batt_mem[wr_idx]     <= item_reg.battery;
                    seen_mem[wr_idx]     <= item_reg.now_ms;
                    res_reg.slot_valid   <= 1'b1;
                    res_reg.slot_index   <= 3'(wr_idx);
                    res_reg.publish      <= pub;
                    res_reg.count_out    <= item_reg.motion_count;
                    res_reg.battery_out  <= item_reg.battery;
                    res_reg.occupied_out <= item_reg.occupied;
                end
                else
                    res_reg.table_full <= 1'b1;
            end
            B_QUERY:
            begin
                res_reg.slot_index <= item_reg.query_slot[2:0];
                if (slot_used)
                begin
                    res_reg.slot_valid  <= 1'b1;
                    res_reg.count_out   <= rd_motion;
                    res_reg.battery_out <= rd_batt;
                end
                diff_reg <= age_ms;
            end
            B_AGE_MUL:
                prod_reg <= 61'(diff_reg) * 61'(AGE_RECIP);
            B_AGE_CAP:
            begin
                if (res_reg.slot_valid)
                    res_reg.age_seconds <= (secs > 23'(cfg.age_cap_seconds))
                                           ? cfg.age_cap_seconds : secs[15:0];
            end
            default:
            begin
            end
        endcase
        if (out_load)
            out_res_reg <= res_out;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.table_full, out_res_reg.publish, out_res_reg.slot_valid};
    assign m_tdata  = {out_res_reg.visible_count, out_res_reg.age_seconds,
                       out_res_reg.occupied_out, out_res_reg.battery_out,
                       out_res_reg.count_out, out_res_reg.slot_index};

endmodule

`default_nettype wire

// ===== src/keyed_device_slot_table_with_aging.sv =====
// Top level of the keyed device slot table with aging.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: request fields
//  m_*      out  m_tvalid/m_tready  m_tuser: flags; m_tdata: slot data and counts
//  cfg_*    in   cfg_we             cfg_addr selects the register, cfg_wdata
//
// An advertisement visits one slot per cycle for the match and free-slot search,
// then writes; a sweep visits every slot in turn; a query reads the slot, multiplies
// its age by the reciprocal of 1000 and saturates. The back end works one item
// at a time; a two-entry queue takes up to two further transfers while it is busy.
// Reset empties every slot and loads the default limits; the slot data is not cleared.
// A stalled result holds in the output register while the back end takes the next item.
`default_nettype none

module keyed_device_slot_table_with_aging
    import kdst_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] now_ms, [79:32] device_addr, [87:80] payload_len,
    // [119:88] motion_count, [127:120] battery_raw, [135:128] occupied_raw,
    // [139:136] query_slot, [143:140] zero
    input  wire logic [143:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [2:0] slot_index, [34:3] count_out, [43:35] battery_out,
    // [51:44] occupied_out, [67:52] age_seconds, [71:68] visible_count
    output logic [71:0]       m_tdata,
    // [0] slot_valid, [1] publish, [2] table_full
    output logic [2:0]        m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    kdst_cfg_t  cfg_reg;
    kdst_item_t front_item;
    kdst_item_t queue_item;
    logic       queue_valid;
    logic       queue_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offline_after_ms <= 32'd30000;
            cfg_reg.remove_after_ms  <= 32'd300000;
            cfg_reg.age_cap_seconds  <= 16'd65535;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_OFFLINE: cfg_reg.offline_after_ms <= cfg_wdata;
                CFG_REMOVE:  cfg_reg.remove_after_ms  <= cfg_wdata;
                CFG_AGE_CAP: cfg_reg.age_cap_seconds  <= cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    kdst_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (front_item)
    );

    kdst_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_pop   (queue_pop),
        .out_item  (queue_item)
    );

    kdst_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (queue_valid),
        .q_pop    (queue_pop),
        .q_item   (queue_item),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A publish only comes with a placed advertisement
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && !m_tuser[2]))
        else $error("publish without a placed slot");

    // A non-empty slot lies below the visible count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ((SLOTS > 8) || (m_tdata[71:68] > {1'b0, m_tdata[2:0]})))
        else $error("reported slot beyond the visible count");

    // The queue only fills through an accepted transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input stalled without a transfer");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the keyed device slot table with aging.
`default_nettype none

module testbench
    import kdst_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOTS         = 8;
    localparam int          ADDR_POOL     = 12;
    localparam int          PHASE_ITEMS   = 265;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int unsigned MS_PER_SECOND = 1000;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam logic [31:0] OFFLINE_RESET = 32'd30000;
    localparam logic [31:0] REMOVE_RESET  = 32'd300000;
    localparam logic [15:0] CAP_RESET     = 16'hFFFF;
    localparam logic [31:0] ONES32        = 32'hFFFF_FFFF;
    localparam logic [47:0] ONES48        = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] now;
        logic [47:0] addr;
        logic [7:0]  plen;
        logic [31:0] cnt;
        logic [7:0]  braw;
        logic [7:0]  oraw;
        logic [3:0]  qs;
    } sensor_req_t;

    typedef struct {
        sensor_req_t rq;
        bit          fixed;
        kdst_res_t   want;
    } plan_row_t;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_mode_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [1:0]   s_tuser = REQ_ADV;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = CFG_OFFLINE;
    logic [31:0]  cfg_wdata = '0;

    // Own copy of the table and its limits
    kdst_status_t slot_state [SLOTS];
    logic [47:0]  slot_key   [SLOTS];
    logic [31:0]  slot_count [SLOTS];
    logic [8:0]   slot_batt  [SLOTS];
    logic [31:0]  slot_stamp [SLOTS];
    logic [31:0]  lim_offline = OFFLINE_RESET;
    logic [31:0]  lim_remove = REMOVE_RESET;
    logic [15:0]  lim_cap = CAP_RESET;

    kdst_res_t    replies_due [$];
    plan_row_t    plan [$];

    logic [47:0]  pool_addr [ADDR_POOL];
    logic [31:0]  pool_cnt  [ADDR_POOL];
    logic [7:0]   pool_batt [ADDR_POOL];
    logic [31:0]  clock_ms = '0;

    int           burst_left = 0;
    int           stall_left = 0;
    rx_mode_t     rx_mode = RX_OPEN;
    int           quiet_cycles = 0;
    int           fail_count = 0;
    int           n_items = 0;
    int           n_results = 0;
    int           n_placed = 0;
    int           n_publish = 0;
    int           n_full = 0;
    int           n_queries = 0;
    int           n_offlined = 0;
    int           n_cleared = 0;

    keyed_device_slot_table_with_aging #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Work out the one result a request gives and move the table along with it
    function automatic kdst_res_t table_response(input sensor_req_t rq);
        kdst_res_t   r;
        int          hit;
        int          i;
        bit          changed;
        logic [8:0]  batt;
        logic [31:0] age;
        logic [31:0] secs;
        r = '0;
        hit = -1;
        changed = 1'b1;
        batt = (rq.plen >= BATT_PAYLOAD) ? {1'b0, rq.braw} : BATT_NONE;
        if (rq.req == REQ_ADV && rq.plen >= MIN_PAYLOAD) begin
            for (i = 0; i < SLOTS; i++)
                if (hit < 0 && slot_state[i] != ST_EMPTY && slot_key[i] == rq.addr)
                    hit = i;
            if (hit >= 0)
                changed = (slot_count[hit] != rq.cnt) || (slot_batt[hit] != batt);
            else
                for (i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_state[i] == ST_EMPTY)
                        hit = i;
            if (hit < 0) begin
                r.table_full = 1'b1;
                n_full++;
            end
            else begin
                slot_key[hit] = rq.addr;
                slot_count[hit] = rq.cnt;
                slot_batt[hit] = batt;
                slot_stamp[hit] = rq.now;
                slot_state[hit] = ST_ACTIVE;
                r.slot_valid = 1'b1;
                r.slot_index = hit[2:0];
                r.publish = changed;
                r.count_out = rq.cnt;
                r.battery_out = batt;
                r.occupied_out = (rq.plen >= OCC_PAYLOAD) ? rq.oraw : 8'd0;
                n_placed++;
                if (changed)
                    n_publish++;
            end
        end
        else if (rq.req == REQ_SWEEP) begin
            for (i = 0; i < SLOTS; i++)
                if (slot_state[i] != ST_EMPTY) begin
                    // age wraps with the millisecond clock
                    age = rq.now - slot_stamp[i];
                    if (age > lim_remove) begin
                        slot_state[i] = ST_EMPTY;
                        slot_key[i] = '0;
                        slot_count[i] = '0;
                        slot_batt[i] = '0;
                        slot_stamp[i] = '0;
                        n_cleared++;
                    end
                    else if (age > lim_offline && slot_state[i] == ST_ACTIVE) begin
                        slot_state[i] = ST_OFFLINE;
                        n_offlined++;
                    end
                end
        end
        else if (rq.req == REQ_QUERY) begin
            n_queries++;
            if (rq.qs < SLOTS) begin
                r.slot_index = rq.qs[2:0];
                if (slot_state[rq.qs] != ST_EMPTY) begin
                    secs = (rq.now - slot_stamp[rq.qs]) / MS_PER_SECOND;
                    r.slot_valid = 1'b1;
                    r.count_out = slot_count[rq.qs];
                    r.battery_out = slot_batt[rq.qs];
                    r.age_seconds = (secs > 32'(lim_cap)) ? lim_cap : secs[15:0];
                end
            end
        end
        for (i = 0; i < SLOTS; i++)
            if (slot_state[i] != ST_EMPTY)
                r.visible_count = 4'(i + 1);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_request(input sensor_req_t rq, input bit fixed, input kdst_res_t want);
        kdst_res_t predicted;
        s_tvalid <= 1'b1;
        s_tuser <= rq.req;
        s_tdata <= {4'b0, rq.qs, rq.oraw, rq.braw, rq.cnt, rq.plen, rq.addr, rq.now};
        do @(posedge clk); while (!s_tready);
        predicted = table_response(rq);
        replies_due.push_back(fixed ? want : predicted);
        n_items++;
        if (burst_left != 0)
            burst_left--;
        else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Hold the sender until every outstanding result has been transferred
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (replies_due.size() != 0);
    endtask

    task automatic plan_row(input logic [1:0] req, input logic [31:0] now,
                            input logic [47:0] addr, input logic [7:0] plen,
                            input logic [31:0] cnt, input logic [7:0] braw,
                            input logic [7:0] oraw, input logic [3:0] qs,
                            input bit fixed, input logic [2:0] idx,
                            input logic full, input logic [3:0] vis);
        plan_row_t row;
        row.rq = '{req: req, now: now, addr: addr, plen: plen, cnt: cnt,
                   braw: braw, oraw: oraw, qs: qs};
        row.fixed = fixed;
        row.want = '0;
        row.want.slot_index = idx;
        row.want.table_full = full;
        row.want.visible_count = vis;
        plan.push_back(row);
    endtask

    task automatic run_phase(input logic [31:0] offline_ms, input logic [31:0] remove_ms,
                             input logic [15:0] cap_s, input int items,
                             input int unsigned step_max);
        sensor_req_t rq;
        int          k;
        int          p;
        int unsigned pick;
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= CFG_OFFLINE;
        cfg_wdata <= offline_ms;
        @(posedge clk);
        cfg_addr <= CFG_REMOVE;
        cfg_wdata <= remove_ms;
        @(posedge clk);
        cfg_addr <= CFG_AGE_CAP;
        cfg_wdata <= {16'd0, cap_s};
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_offline = offline_ms;
        lim_remove = remove_ms;
        lim_cap = cap_s;
        for (k = 0; k < items; k++) begin
            clock_ms += $urandom_range(0, step_max);
            if ($urandom_range(0, 199) == 0)
                clock_ms = $urandom;
            rq.now = clock_ms;
            rq.addr = {16'($urandom), 32'($urandom)};
            rq.plen = 8'($urandom);
            rq.cnt = $urandom;
            rq.braw = 8'($urandom);
            rq.oraw = 8'($urandom);
            rq.qs = 4'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                rq.req = REQ_ADV;
                p = $urandom_range(0, ADDR_POOL - 1);
                // mostly known devices so the table fills, matches and overflows
                if ($urandom_range(0, 19) != 0)
                    rq.addr = pool_addr[p];
                case ($urandom_range(0, 9))
                    0: rq.plen = 8'($urandom_range(0, 5));
                    1: rq.plen = MIN_PAYLOAD;
                    2: rq.plen = BATT_PAYLOAD;
                    default: rq.plen = 8'($urandom_range(8, 255));
                endcase
                if ($urandom_range(0, 1) == 0) begin
                    rq.cnt = pool_cnt[p];
                    rq.braw = pool_batt[p];
                end
                else begin
                    pool_cnt[p] = rq.cnt;
                    pool_batt[p] = rq.braw;
                end
            end
            else if (pick < 70)
                rq.req = REQ_SWEEP;
            else if (pick < 95) begin
                rq.req = REQ_QUERY;
                rq.qs = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                                    : 4'($urandom_range(0, 7));
            end
            else
                rq.req = REQ_UNUSED;
            send_request(rq, 1'b0, '0);
            if ($urandom_range(0, 149) == 0)
                drain();
        end
    endtask

    // Receiver: stall on a pattern that changes now and then
    always @(posedge clk) begin
        if ($urandom_range(0, 299) == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else begin
            case (rx_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 30);
                end
            endcase
        end
    end

    always @(posedge clk) begin
        kdst_res_t want;
        if (rst_n && m_tvalid && m_tready) begin
            n_results++;
            if (replies_due.size() == 0) begin
                $error("result transfer with nothing outstanding");
                fail_count++;
            end
            else begin
                want = replies_due.pop_front();
                check_field("slot_valid", 32'(want.slot_valid), 32'(m_tuser[0]));
                check_field("publish", 32'(want.publish), 32'(m_tuser[1]));
                check_field("table_full", 32'(want.table_full), 32'(m_tuser[2]));
                check_field("slot_index", 32'(want.slot_index), 32'(m_tdata[2:0]));
                check_field("count_out", want.count_out, m_tdata[34:3]);
                check_field("battery_out", 32'(want.battery_out), 32'(m_tdata[43:35]));
                check_field("occupied_out", 32'(want.occupied_out), 32'(m_tdata[51:44]));
                check_field("age_seconds", 32'(want.age_seconds), 32'(m_tdata[67:52]));
                check_field("visible_count", 32'(want.visible_count), 32'(m_tdata[71:68]));
            end
        end
    end

    // Watchdog: give up when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int          k;
        logic [31:0] rand_off;
        for (k = 0; k < SLOTS; k++)
            slot_state[k] = ST_EMPTY;
        for (k = 0; k < ADDR_POOL; k++) begin
            pool_addr[k] = {16'($urandom), 32'($urandom)};
            pool_cnt[k] = $urandom;
            pool_batt[k] = 8'($urandom);
        end

        // empty table, unused and out-of-range requests, short payloads
        plan_row(REQ_QUERY, 32'd0, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0, 1, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_SWEEP, 32'd0, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0, 1, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_UNUSED, ONES32, ONES48, 8'hFF, ONES32, 8'hFF, 8'hFF, 4'hF,
                 1, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_QUERY, 32'd0, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd15, 1, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_QUERY, 32'd0, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd8, 1, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd0, ONES48, 8'd5, 32'd9, 8'd9, 8'd9, 4'd0, 1, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd0, 48'h0, 8'd0, 32'd9, 8'd9, 8'd9, 4'd0, 1, 3'd0, 1'b0, 4'd0);
        // fill the table; no battery, then battery change, repeat, count change
        plan_row(REQ_ADV, 32'd1000, 48'h0, 8'd6, 32'd0, 8'd0, 8'hFF, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, ONES32, ONES48, 8'hFF, ONES32, 8'hFF, 8'hFF, 4'd0,
                 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd2000, 48'h0, 8'd7, 32'd0, 8'd0, 8'hFF, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd3000, 48'h0, 8'd7, 32'd0, 8'd0, 8'h11, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd4000, 48'h0, 8'd8, 32'd1, 8'd0, 8'h5A, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd5000, 48'h1, 8'd8, 32'd2, 8'd50, 8'd1, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd5000, 48'h2, 8'd8, 32'd3, 8'd60, 8'd0, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd5000, 48'h3, 8'd9, 32'd4, 8'd70, 8'd1, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd5000, 48'h4, 8'd7, 32'd5, 8'd80, 8'd0, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd5000, 48'h5, 8'd6, 32'd6, 8'd90, 8'd1, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_ADV, 32'd5000, 48'h6, 8'd8, 32'd7, 8'd100, 8'd2, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        // table full: unknown device dropped
        plan_row(REQ_ADV, 32'd6000, 48'h7, 8'd8, 32'd8, 8'd1, 8'd1, 4'd0, 1, 3'd0, 1'b1, 4'd8);
        // ages across the wrap of the clock, saturation, then offline and removal
        plan_row(REQ_QUERY, 32'd0, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd1, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_QUERY, 32'hFFFF_0000, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0,
                 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_QUERY, 32'd6999, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd7, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_SWEEP, 32'd40000, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0, 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_SWEEP, 32'd350000, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0,
                 0, 3'd0, 1'b0, 4'd0);
        plan_row(REQ_QUERY, 32'd350000, 48'h0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd3,
                 1, 3'd3, 1'b0, 4'd0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        foreach (plan[k])
            send_request(plan[k].rq, plan[k].fixed, plan[k].want);

        clock_ms = 32'd1000;
        run_phase(OFFLINE_RESET, REMOVE_RESET, CAP_RESET, PHASE_ITEMS, 8000);
        run_phase(32'd0, 32'd0, 16'd0, PHASE_ITEMS, 2);
        run_phase(ONES32, ONES32, 16'hFFFF, PHASE_ITEMS, 50_000_000);
        rand_off = $urandom_range(1000, 60000);
        run_phase(rand_off, rand_off + $urandom_range(0, 200000), 16'($urandom_range(1, 120)),
                  PHASE_ITEMS, rand_off / 3 + 1);
        // remove limit below the offline limit
        run_phase(32'd200000, 32'd50000, 16'd30000, PHASE_ITEMS, 20000);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (replies_due.size() != 0) begin
            $error("%0d results never arrived", replies_due.size());
            fail_count++;
        end
        $display("Sent %0d requests: %0d advertisements placed (%0d published), %0d dropped full,",
                 n_items, n_placed, n_publish, n_full);
        $display("%0d queries; sweeps took %0d slots offline and cleared %0d; %0d results checked",
                 n_queries, n_offlined, n_cleared, n_results);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
